/* rtl/core/pdf_literal_string_unescape_core_macros.svh */
// Assertion macros shared by the literal string unescape RTL.
`ifndef PDF_LITERAL_STRING_UNESCAPE_CORE_MACROS_SVH
`define PDF_LITERAL_STRING_UNESCAPE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define PLSU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define PLSU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define PLSU_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PLSU_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/core/plsu_pkg.sv */
// Types and constants of the literal string unescape core.
`timescale 1ns / 1ps
package plsu_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SEVEN  = 8'h37;

  localparam logic [7:0] CODE_LF = 8'h0A;
  localparam logic [7:0] CODE_CR = 8'h0D;
  localparam logic [7:0] CODE_HT = 8'h09;
  localparam logic [7:0] CODE_BS = 8'h08;
  localparam logic [7:0] CODE_FF = 8'h0C;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_end;
    logic       end_status;
  } result_t;

  // Up to two results are produced per input transaction.
  typedef struct packed {
    logic [1:0] num;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

/* rtl/core/plsu_if.sv */
// Valid/ready channel interfaces for the input bytes and the decoded results.
`timescale 1ns / 1ps
interface plsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;

  modport source (output valid, output in_byte, output last_byte, input ready);
  modport sink (input valid, input in_byte, input last_byte, output ready);
endinterface

interface plsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       string_end;
  logic       end_status;

  modport source (output valid, output out_byte, output byte_valid, output string_end,
                  output end_status, input ready);
  modport sink (input valid, input out_byte, input byte_valid, input string_end,
                input end_status, output ready);
endinterface

/* rtl/core/plsu_decode.sv */
// Escape, octal and nesting decoder: turns one raw byte into up to two results.
`timescale 1ns / 1ps
`include "pdf_literal_string_unescape_core_macros.svh"
module plsu_decode import plsu_pkg::*; #(
  parameter int MAX_NESTING = 255,
  localparam int NW = $clog2(MAX_NESTING + 1)
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic       last_byte,
  output push_t      push
);

  typedef enum logic [1:0] {
    M_TEXT = 2'd0,
    M_ESC  = 2'd1,
    M_OCT1 = 2'd2,
    M_OCT2 = 2'd3
  } mode_t;

  mode_t          mode_r, mode_nxt;
  logic [NW-1:0]  nest_r, nest_nxt, nest_dec;
  logic [5:0]     oct_r, oct_nxt;

  logic       is_oct;
  logic [2:0] dig;
  logic       do_text, closed, ending;
  logic       a_v, b_v, c_v, e0_v, e1_v;
  logic [7:0] a_b, b_b, c_b, e0_b, e1_b;
  result_t    r0, r1;
  logic [1:0] num;

  assign is_oct = (in_byte >= CH_ZERO) && (in_byte <= CH_SEVEN);
  assign dig    = in_byte[2:0];

  always_comb begin
    mode_nxt = mode_r;
    nest_nxt = nest_r;
    nest_dec = nest_r;
    oct_nxt  = oct_r;
    do_text  = 1'b0;
    closed   = 1'b0;
    a_v = 1'b0; a_b = '0;
    b_v = 1'b0; b_b = '0;
    c_v = 1'b0; c_b = '0;

    unique case (mode_r)
      M_ESC: begin
        mode_nxt = M_TEXT;
        a_v      = 1'b1;
        case (in_byte)
          CH_N: a_b = CODE_LF;
          CH_R: a_b = CODE_CR;
          CH_T: a_b = CODE_HT;
          CH_B: a_b = CODE_BS;
          CH_F: a_b = CODE_FF;
          default: begin
            if (is_oct) begin
              a_v      = 1'b0;
              oct_nxt  = {3'b000, dig};
              mode_nxt = M_OCT1;
            end else begin
              a_b = in_byte;
            end
          end
        endcase
      end
      M_OCT1: begin
        if (is_oct) begin
          oct_nxt  = {oct_r[2:0], dig};
          mode_nxt = M_OCT2;
        end else begin
          a_v      = 1'b1;
          a_b      = {2'b00, oct_r};
          oct_nxt  = '0;
          mode_nxt = M_TEXT;
          do_text  = 1'b1;
        end
      end
      M_OCT2: begin
        a_v      = 1'b1;
        oct_nxt  = '0;
        mode_nxt = M_TEXT;
        if (is_oct) begin
          // Third digit: the value keeps only its low eight bits.
          a_b = {oct_r[4:0], dig};
        end else begin
          a_b     = {2'b00, oct_r};
          do_text = 1'b1;
        end
      end
      M_TEXT: begin
        do_text = 1'b1;
      end
    endcase

    if (do_text) begin
      if (in_byte == CH_BSLASH) begin
        mode_nxt = M_ESC;
      end else if (in_byte == CH_LPAREN) begin
        if (nest_r < NW'(MAX_NESTING)) begin
          nest_nxt = nest_r + NW'(1);
        end
        b_v = 1'b1;
        b_b = in_byte;
      end else if (in_byte == CH_RPAREN) begin
        nest_dec = (nest_r != '0) ? nest_r - NW'(1) : nest_r;
        nest_nxt = nest_dec;
        if (nest_dec != '0) begin
          b_v = 1'b1;
          b_b = in_byte;
        end else begin
          closed = 1'b1;
        end
      end else begin
        b_v = 1'b1;
        b_b = in_byte;
      end
    end

    ending = closed || last_byte;

    // Data ran out inside an octal run: flush what was gathered.
    if (ending && !closed && (mode_nxt == M_OCT1 || mode_nxt == M_OCT2)) begin
      c_v = 1'b1;
      c_b = {2'b00, oct_nxt};
    end

    if (a_v) begin
      e0_v = 1'b1; e0_b = a_b;
      e1_v = b_v || c_v;
      e1_b = b_v ? b_b : c_b;
    end else if (b_v) begin
      e0_v = 1'b1; e0_b = b_b;
      e1_v = c_v;  e1_b = c_b;
    end else begin
      e0_v = c_v;  e0_b = c_b;
      e1_v = 1'b0; e1_b = '0;
    end

    r0 = '{out_byte: e0_b, byte_valid: e0_v, string_end: 1'b0, end_status: 1'b0};
    r1 = '{out_byte: e1_b, byte_valid: e1_v, string_end: 1'b0, end_status: 1'b0};
    num = e1_v ? 2'd2 : (e0_v ? 2'd1 : 2'd0);

    if (ending) begin
      // An empty result carries the end mark when nothing else was decoded.
      if (!e0_v) begin
        num = 2'd1;
      end
      if (e1_v) begin
        r1.string_end = 1'b1;
        r1.end_status = !closed;
      end else begin
        r0.string_end = 1'b1;
        r0.end_status = !closed;
      end
      mode_nxt = M_TEXT;
      nest_nxt = NW'(1);
      oct_nxt  = '0;
    end
  end

  assign push.num = accept ? num : 2'd0;
  assign push.r0  = r0;
  assign push.r1  = r1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_TEXT;
      nest_r <= NW'(1);
      oct_r  <= '0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      nest_r <= nest_nxt;
      oct_r  <= oct_nxt;
    end
  end

  `PLSU_ASSERT_IMP(a_status_tagged, clk, rst_n, push.num != 2'd0 && push.r0.end_status, push.r0.string_end)
  `PLSU_ASSERT_NXT(a_rearm, clk, rst_n, push.num != 2'd0 && (push.r0.string_end || push.r1.string_end), mode_r == M_TEXT && oct_r == 6'd0 && nest_r == NW'(1))

endmodule

/* rtl/core/plsu_queue.sv */
// Four-entry result queue: takes up to two results per cycle, gives one per pop.
`timescale 1ns / 1ps
`include "pdf_literal_string_unescape_core_macros.svh"
module plsu_queue import plsu_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  push_t   push,
  input  logic    pop,
  output result_t head,
  output logic    head_valid,
  output logic    room
);

  result_t            q_r [QDEPTH];
  logic [QAW-1:0]     wr_r, wr_nxt, rd_r, rd_nxt;
  logic [QCW-1:0]     cnt_r, cnt_nxt;

  assign head       = q_r[rd_r];
  assign head_valid = (cnt_r != '0);
  // Room for a full two-result transaction, judged on the registered count.
  assign room       = (cnt_r <= QCW'(QDEPTH - 2));

  assign wr_nxt  = wr_r + QAW'(push.num);
  assign rd_nxt  = rd_r + QAW'(pop);
  assign cnt_nxt = cnt_r + QCW'(push.num) - QCW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      q_r[wr_r] <= push.r0;
    end
    if (push.num == 2'd2) begin
      q_r[wr_r + QAW'(1)] <= push.r1;
    end
  end

  `PLSU_ASSERT_IMP(a_push_room, clk, rst_n, push.num != 2'd0, cnt_r <= QCW'(QDEPTH - 2))
  `PLSU_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= QCW'(QDEPTH))

endmodule

/* rtl/core/pdf_literal_string_unescape_core.sv */
// Decodes the body bytes of a PDF literal string into the bytes they stand for.
// One raw byte is taken per cycle while the queue has room; its results are written to
// the output queue at the accepting edge and reach the output port in order. A byte yields
// zero, one or two results (two when a non-octal byte breaks an octal run and is then
// passed through as text); the output port gives one result per cycle while out_ch.ready
// is high, so it sets the sustained rate: one byte per cycle while bytes
// yield at most one result, otherwise one result per cycle. The four-entry output
// queue absorbs the difference; the input is ready while at least two entries are free.
// The string end is tagged on the last result of the closing byte, or on an empty
// result (byte_valid low) when the closing byte decodes to nothing, and the decoder
// then re-arms for the next string.
`timescale 1ns / 1ps
module pdf_literal_string_unescape_core import plsu_pkg::*; #(
  parameter int MAX_NESTING = 255
) (
  input  logic               clk,
  input  logic               rst_n,
  plsu_in_if.sink            in_ch,
  plsu_out_if.source         out_ch
);

  push_t   push;
  result_t head;
  logic    head_valid, room, accept, pop;

  assign accept      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = room;
  assign pop         = out_ch.valid && out_ch.ready;

  plsu_decode #(
    .MAX_NESTING (MAX_NESTING)
  ) u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_byte   (in_ch.in_byte),
    .last_byte (in_ch.last_byte),
    .push      (push)
  );

  plsu_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .room       (room)
  );

  assign out_ch.valid      = head_valid;
  assign out_ch.out_byte   = head.out_byte;
  assign out_ch.byte_valid = head.byte_valid;
  assign out_ch.string_end = head.string_end;
  assign out_ch.end_status = head.end_status;

endmodule

/* tb/tb_pdf_literal_string_unescape_core.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the PDF literal string unescape core.
module tb_pdf_literal_string_unescape_core import plsu_pkg::*;;

  localparam int NEST_MAX    = 255;
  localparam int ITEM_GOAL   = 1550;
  localparam int STALL_LIMIT = 5000;
  localparam int N_DIR       = 31;

  typedef enum logic [1:0] {SCAN_TEXT, SCAN_ESC, SCAN_OCT1, SCAN_OCT2} scan_state_t;

  typedef struct packed {
    logic [7:0] raw;
    logic       last;
  } raw_item_t;

  typedef struct packed {
    logic [7:0] raw;
    logic       last;
    logic       typed;
    logic       has_res;
    result_t    res;
  } dir_row_t;

  logic clk;
  logic rst_n;

  plsu_in_if  in_ch ();
  plsu_out_if out_ch ();

  pdf_literal_string_unescape_core #(.MAX_NESTING(NEST_MAX)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predictor state, mirrors the decoder.
  scan_state_t scan_st;
  logic [7:0]  nest_depth;
  logic [5:0]  oct_acc;
  result_t     step_res [2];
  int          step_n;

  result_t   decoded_q [$];
  dir_row_t  note_q [$];
  raw_item_t plan_q [$];

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int n_fed         = 0;
  int n_checked     = 0;
  int n_closed      = 0;
  int n_ranout      = 0;
  int fail_cnt      = 0;
  int idle_cycles   = 0;

  // Typed expectations cover the reset state, the byte extremes and the ways a string ends.
  dir_row_t dir_rows [N_DIR] = '{
    '{8'h00,     1'b0, 1'b1, 1'b1, {8'h00, 1'b1, 1'b0, 1'b0}},
    '{8'hFF,     1'b0, 1'b1, 1'b1, {8'hFF, 1'b1, 1'b0, 1'b0}},
    '{CH_BSLASH, 1'b0, 1'b0, 1'b0, '0},
    '{CH_N,      1'b0, 1'b0, 1'b0, '0},
    '{CH_BSLASH, 1'b0, 1'b0, 1'b0, '0},
    '{CH_R,      1'b0, 1'b0, 1'b0, '0},
    '{CH_BSLASH, 1'b0, 1'b0, 1'b0, '0},
    '{CH_T,      1'b0, 1'b0, 1'b0, '0},
    '{CH_BSLASH, 1'b0, 1'b0, 1'b0, '0},
    '{CH_B,      1'b0, 1'b0, 1'b0, '0},
    '{CH_BSLASH, 1'b0, 1'b0, 1'b0, '0},
    '{CH_F,      1'b0, 1'b0, 1'b0, '0},
    '{CH_BSLASH, 1'b0, 1'b0, 1'b0, '0},
    '{CH_BSLASH, 1'b0, 1'b0, 1'b0, '0},
    '{CH_BSLASH, 1'b0, 1'b0, 1'b0, '0},
    '{CH_RPAREN, 1'b0, 1'b0, 1'b0, '0},
    '{CH_BSLASH, 1'b0, 1'b0, 1'b0, '0},
    '{8'h71,     1'b0, 1'b0, 1'b0, '0},
    '{CH_BSLASH, 1'b0, 1'b0, 1'b0, '0},
    '{CH_SEVEN,  1'b0, 1'b0, 1'b0, '0},
    '{CH_SEVEN,  1'b0, 1'b0, 1'b0, '0},
    '{CH_SEVEN,  1'b0, 1'b0, 1'b0, '0},
    '{CH_BSLASH, 1'b0, 1'b0, 1'b0, '0},
    '{8'h31,     1'b0, 1'b0, 1'b0, '0},
    '{CH_LPAREN, 1'b0, 1'b0, 1'b0, '0},
    '{CH_RPAREN, 1'b0, 1'b0, 1'b0, '0},
    '{CH_RPAREN, 1'b0, 1'b1, 1'b1, {8'h00, 1'b0, 1'b1, 1'b0}},
    '{CH_BSLASH, 1'b1, 1'b1, 1'b1, {8'h00, 1'b0, 1'b1, 1'b1}},
    '{CH_BSLASH, 1'b0, 1'b0, 1'b0, '0},
    '{8'h34,     1'b1, 1'b1, 1'b1, {8'h04, 1'b1, 1'b1, 1'b1}},
    '{CH_RPAREN, 1'b1, 1'b1, 1'b1, {8'h00, 1'b0, 1'b1, 1'b0}}
  };

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void reset_scan();
    scan_st    = SCAN_TEXT;
    nest_depth = 8'd1;
    oct_acc    = '0;
  endfunction

  function automatic void emit_byte(logic [7:0] v);
    step_res[step_n] = {v, 1'b1, 1'b0, 1'b0};
    step_n++;
  endfunction

  function automatic logic is_oct(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_SEVEN);
  endfunction

  // Handles a byte as plain text; returns 1 when it is the matching close.
  function automatic logic text_char(logic [7:0] c);
    text_char = 1'b0;
    if (c == CH_BSLASH) begin
      scan_st = SCAN_ESC;
    end else if (c == CH_LPAREN) begin
      if (nest_depth < NEST_MAX) nest_depth++;
      emit_byte(c);
    end else if (c == CH_RPAREN) begin
      if (nest_depth != 0) nest_depth--;
      if (nest_depth != 0) emit_byte(c);
      else text_char = 1'b1;
    end else begin
      emit_byte(c);
    end
  endfunction

  function automatic void decode_step(logic [7:0] c, logic lst);
    logic [7:0] dig;
    logic       closed;
    dig    = c - CH_ZERO;
    closed = 1'b0;
    step_n = 0;
    case (scan_st)
      SCAN_ESC: begin
        scan_st = SCAN_TEXT;
        if (c == CH_N) emit_byte(CODE_LF);
        else if (c == CH_R) emit_byte(CODE_CR);
        else if (c == CH_T) emit_byte(CODE_HT);
        else if (c == CH_B) emit_byte(CODE_BS);
        else if (c == CH_F) emit_byte(CODE_FF);
        else if (is_oct(c)) begin
          oct_acc = {3'b000, dig[2:0]};
          scan_st = SCAN_OCT1;
        end else emit_byte(c);
      end
      SCAN_OCT1: begin
        if (is_oct(c)) begin
          oct_acc = {oct_acc[2:0], dig[2:0]};
          scan_st = SCAN_OCT2;
        end else begin
          emit_byte({2'b00, oct_acc});
          oct_acc = '0;
          scan_st = SCAN_TEXT;
          closed  = text_char(c);
        end
      end
      SCAN_OCT2: begin
        // A third digit completes the byte; only its low eight bits survive.
        if (is_oct(c)) emit_byte({oct_acc[4:0], dig[2:0]});
        else emit_byte({2'b00, oct_acc});
        oct_acc = '0;
        scan_st = SCAN_TEXT;
        if (!is_oct(c)) closed = text_char(c);
      end
      default: closed = text_char(c);
    endcase
    if (closed || lst) begin
      if (!closed && (scan_st == SCAN_OCT1 || scan_st == SCAN_OCT2)) emit_byte({2'b00, oct_acc});
      if (step_n == 0) begin
        step_res[0] = '0;
        step_n      = 1;
      end
      step_res[step_n-1].string_end = 1'b1;
      step_res[step_n-1].end_status = !closed;
      if (closed) n_closed++;
      else n_ranout++;
      reset_scan();
    end
  endfunction

  function automatic void check_field(string fname, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", fname, want, got);
      fail_cnt++;
    end
  endfunction

  always @(posedge clk) begin : scoreboard
    result_t  want;
    dir_row_t note;
    logic     use_note;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        use_note = 1'b0;
        if (note_q.size() != 0) begin
          note     = note_q.pop_front();
          use_note = note.typed;
        end
        decode_step(in_ch.in_byte, in_ch.last_byte);
        if (use_note) begin
          if (note.has_res) decoded_q.insert(decoded_q.size(), note.res);
        end else begin
          for (int i = 0; i < step_n; i++) decoded_q.insert(decoded_q.size(), step_res[i]);
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        if (decoded_q.size() == 0) begin
          $error("result with nothing expected: out_byte 0x%0h byte_valid %0b string_end %0b",
                 out_ch.out_byte, out_ch.byte_valid, out_ch.string_end);
          fail_cnt++;
        end else begin
          want = decoded_q.pop_front();
          n_checked++;
          check_field("out_byte", want.out_byte, out_ch.out_byte);
          check_field("byte_valid", want.byte_valid, out_ch.byte_valid);
          check_field("string_end", want.string_end, out_ch.string_end);
          check_field("end_status", want.end_status, out_ch.end_status);
        end
      end
    end
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $error("no transaction for %0d cycles", STALL_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  task automatic send_byte(logic [7:0] b, logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.in_byte   <= b;
    in_ch.last_byte <= l;
    do @(posedge clk); while (!in_ch.ready);
    n_fed++;
  endtask

  // Lowers valid and holds off until every outstanding decoded byte has been seen.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] c;
    do c = 8'($urandom); while (c == CH_BSLASH || c == CH_LPAREN || c == CH_RPAREN);
    return c;
  endfunction

  // Appends one raw byte to the plan.
  function automatic void add_raw(logic [7:0] b, logic l);
    raw_item_t it;
    it.raw  = b;
    it.last = l;
    plan_q.insert(plan_q.size(), it);
  endfunction

  // Builds one string body: mostly well formed, with a share of raw noise.
  task automatic plan_string();
    int         lvl;
    int         k;
    int         n_tok;
    logic [7:0] c;
    plan_q.delete();
    lvl   = 1;
    n_tok = $urandom_range(1, 24);
    if ($urandom_range(99) < 15) begin
      repeat (n_tok) add_raw(8'($urandom), ($urandom_range(15) == 0));
      return;
    end
    repeat (n_tok) begin
      k = $urandom_range(99);
      if (k < 35) begin
        add_raw(plain_byte(), 1'b0);
      end else if (k < 55) begin
        case ($urandom_range(8))
          0: c = CH_N;
          1: c = CH_R;
          2: c = CH_T;
          3: c = CH_B;
          4: c = CH_F;
          5: c = CH_BSLASH;
          6: c = CH_LPAREN;
          7: c = CH_RPAREN;
          default: c = 8'($urandom);
        endcase
        add_raw(CH_BSLASH, 1'b0);
        add_raw(c, 1'b0);
      end else if (k < 75) begin
        add_raw(CH_BSLASH, 1'b0);
        repeat ($urandom_range(1, 3)) add_raw(CH_ZERO + 8'($urandom_range(7)), 1'b0);
      end else if (k < 88 || lvl == 1) begin
        add_raw(CH_LPAREN, 1'b0);
        lvl++;
      end else begin
        add_raw(CH_RPAREN, 1'b0);
        lvl--;
      end
    end
    k = $urandom_range(99);
    if (k < 75) begin
      repeat (lvl) add_raw(CH_RPAREN, 1'b0);
      if ($urandom_range(3) == 0) plan_q[plan_q.size()-1].last = 1'b1;
    end else if (k < 85) begin
      add_raw(CH_BSLASH, 1'b1);
    end else if (k < 93) begin
      add_raw(CH_BSLASH, 1'b0);
      repeat ($urandom_range(1, 2)) add_raw(CH_ZERO + 8'($urandom_range(7)), 1'b0);
      plan_q[plan_q.size()-1].last = 1'b1;
    end else begin
      plan_q[plan_q.size()-1].last = 1'b1;
    end
  endtask

  // Opens past the nesting ceiling, then closes from the saturated count.
  task automatic plan_deep_nest();
    plan_q.delete();
    repeat (NEST_MAX + $urandom_range(1, 6)) begin
      add_raw(CH_LPAREN, 1'b0);
      if ($urandom_range(9) == 0) add_raw(plain_byte(), 1'b0);
    end
    repeat (NEST_MAX) add_raw(CH_RPAREN, 1'b0);
  endtask

  task automatic send_plan();
    foreach (plan_q[i]) send_byte(plan_q[i].raw, plan_q[i].last);
  endtask

  initial begin
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.in_byte   <= '0;
    in_ch.last_byte <= 1'b0;
    reset_scan();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++) begin
      note_q.insert(note_q.size(), dir_rows[i]);
      send_byte(dir_rows[i].raw, dir_rows[i].last);
    end

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 56; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 56; end
        default: begin send_idle_pct = 35; stall_pct = 35; end
      endcase
      wait_drained();
      if (ph == 1) begin
        plan_deep_nest();
        send_plan();
      end
      while (n_fed < N_DIR + (ITEM_GOAL - N_DIR) * (ph + 1) / 4) begin
        plan_string();
        send_plan();
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);

    $display("Fed %0d string bytes and checked %0d decoded results.", n_fed, n_checked);
    $display("Strings closed by parenthesis: %0d, ended by running out of data: %0d.",
             n_closed, n_ranout);
    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
